/* sv/lplr_pkg.sv */
// ---------------------------------------------------------------------------
// lplr_pkg: shared types and constants of the line rasterizer
// Register map codes, fixed field widths and the control/status bundles
// passed between the controller and the datapath.
// ---------------------------------------------------------------------------
package lplr_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_OFFSET_X       = 3'd0,
    CFG_OFFSET_Y       = 3'd1,
    CFG_SCREEN_WIDTH   = 3'd2,
    CFG_SCREEN_HEIGHT  = 3'd3,
    CFG_STACKED_PANELS = 3'd4,
    CFG_ZIGZAG_LAYOUT  = 3'd5
  } cfg_reg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int COORD_W    = 6;
  localparam int COLOR_W    = 8;
  localparam int INDEX_W    = 9;

  localparam logic [6:0] SCREEN_WIDTH_RST  = 7'd32;
  localparam logic [4:0] SCREEN_HEIGHT_RST = 5'd8;

  // row that zigzag mirroring folds around
  localparam int ZIGZAG_TOP = 7;

  typedef struct packed {
    logic load;        // latch the line command
    logic wrap_start;  // kick the modulo units for the first point
    logic wrap_take;   // take the wrapped first point
    logic emit;        // push one pixel write and step the walk
  } ctrl_cmd_t;

  typedef struct packed {
    logic wrap_done;
    logic out_free;
    logic last_point;
  } dp_status_t;

endpackage

/* sv/lplr_if.sv */
// ---------------------------------------------------------------------------
// lplr_if: channel interfaces of the line rasterizer
// Line command input, pixel write output and configuration write channel.
// ---------------------------------------------------------------------------
interface lplr_line_if;
  logic              valid;
  logic              ready;
  logic signed [5:0] start_x;
  logic signed [5:0] start_y;
  logic signed [5:0] end_x;
  logic signed [5:0] end_y;
  logic        [7:0] red_in;
  logic        [7:0] green_in;
  logic        [7:0] blue_in;

  modport source (output valid, start_x, start_y, end_x, end_y, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, red_in, green_in, blue_in,
                  output ready);
endinterface

interface lplr_pix_if;
  logic       valid;
  logic       ready;
  logic [8:0] pixel_index;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last_pixel;

  modport source (output valid, pixel_index, red_out, green_out, blue_out, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_index, red_out, green_out, blue_out, last_pixel,
                  output ready);
endinterface

interface lplr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [6:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/lplr_wrap.sv */
// ---------------------------------------------------------------------------
// lplr_wrap: iterative non-negative modulo unit
// Restoring remainder of a signed 8-bit value by a 7-bit size, one bit per
// cycle, with the negative-operand correction applied at the output.
// ---------------------------------------------------------------------------
module lplr_wrap (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic signed [7:0] value,
  input  logic        [6:0] size,
  output logic              done,
  output logic        [6:0] result
);

  localparam int          ITERS = 8;
  localparam logic [2:0]  LAST_IT = 3'(ITERS - 1);

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] mag_r, mag_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic       neg_r, neg_nxt;

  logic [6:0] s_eff;
  logic [7:0] trial;

  assign s_eff = (size == 7'd0) ? 7'd1 : size;
  assign trial = {rem_r[6:0], mag_r[7]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      mag_nxt  = value[7] ? 8'(-value) : 8'(value);
      rem_nxt  = 8'd0;
      neg_nxt  = value[7];
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, s_eff}) ? trial - {1'b0, s_eff} : trial;
      mag_nxt = {mag_r[6:0], 1'b0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == LAST_IT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
      neg_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      neg_r  <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
  end

  // negative operand with nonzero remainder folds back into range
  assign done   = done_r;
  assign result = (neg_r && rem_r != 8'd0) ? s_eff - rem_r[6:0] : rem_r[6:0];

endmodule

/* sv/lplr_ctrl.sv */
// ---------------------------------------------------------------------------
// lplr_ctrl: line rasterizer sequencer
// Steps one line command through load, first-point wrap and pixel emission.
// ---------------------------------------------------------------------------
module lplr_ctrl import lplr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output ctrl_cmd_t  cmd,
  input  dp_status_t st
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_WRAP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.wrap_start = 1'b1;
        state_nxt      = S_WRAP;
      end
      S_WRAP: begin
        if (st.wrap_done) begin
          cmd.wrap_take = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.last_point) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a wrap result is only taken once the modulo units were started
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wrap_take |-> !$past(cmd.load))
    else $error("wrap taken right after load");

endmodule

/* sv/lplr_dp.sv */
// ---------------------------------------------------------------------------
// lplr_dp: line rasterizer datapath
// Configuration registers, DDA walk with integer/remainder per axis,
// incremental screen wrap, panel mapping and the pixel output register.
// ---------------------------------------------------------------------------
module lplr_dp import lplr_pkg::*; #(
  parameter int PANEL_WIDTH  = 32,
  parameter int PANEL_HEIGHT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        st,
  input  logic signed [5:0] start_x,
  input  logic signed [5:0] start_y,
  input  logic signed [5:0] end_x,
  input  logic signed [5:0] end_y,
  input  logic        [7:0] red_in,
  input  logic        [7:0] green_in,
  input  logic        [7:0] blue_in,
  input  logic              cfg_we,
  input  logic        [2:0] cfg_index,
  input  logic        [6:0] cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic        [8:0] pixel_index,
  output logic        [7:0] red_out,
  output logic        [7:0] green_out,
  output logic        [7:0] blue_out,
  output logic              last_pixel
);

  localparam logic signed [15:0] PW_S  = 16'(PANEL_WIDTH);
  localparam logic signed [15:0] PH_S  = 16'(PANEL_HEIGHT);
  localparam logic signed [15:0] ZZ_S  = 16'(ZIGZAG_TOP);

  typedef struct packed {
    logic signed [6:0] fq;  // floor quotient
    logic        [5:0] fr;  // floor remainder
    logic signed [6:0] tr;  // quotient truncated toward zero
  } axis_t;

  // one DDA step: add the delta to the remainder and carry into the quotient
  function automatic axis_t axis_step(logic signed [6:0] fq, logic [5:0] fr,
                                      logic signed [6:0] d, logic [5:0] steps);
    logic signed [7:0] sum;
    logic signed [7:0] sv;
    axis_t             r;
    sv   = $signed({2'b00, steps});
    sum  = $signed({2'b00, fr}) + $signed({d[6], d});
    r.fq = fq;
    if (sum >= sv) begin
      sum  = sum - sv;
      r.fq = fq + 7'sd1;
    end else if (sum < 8'sd0) begin
      sum  = sum + sv;
      r.fq = fq - 7'sd1;
    end
    r.fr = sum[5:0];
    r.tr = r.fq + ((r.fq < 7'sd0 && r.fr != 6'd0) ? 7'sd1 : 7'sd0);
    return r;
  endfunction

  // configuration
  logic signed [6:0] offset_x_r, offset_y_r;
  logic        [6:0] screen_width_r;
  logic        [4:0] screen_height_r;
  logic              stacked_r, zigzag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r      <= 7'sd0;
      offset_y_r      <= 7'sd0;
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
      stacked_r       <= 1'b0;
      zigzag_r        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_OFFSET_X:       offset_x_r      <= $signed(cfg_data);
        CFG_OFFSET_Y:       offset_y_r      <= $signed(cfg_data);
        CFG_SCREEN_WIDTH:   screen_width_r  <= cfg_data;
        CFG_SCREEN_HEIGHT:  screen_height_r <= cfg_data[4:0];
        CFG_STACKED_PANELS: stacked_r       <= cfg_data[0];
        CFG_ZIGZAG_LAYOUT:  zigzag_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // line setup from the command fields
  logic              eq_x, eq_y;
  logic signed [5:0] hi_x, lo_x, hi_y, lo_y, bx, by;
  logic signed [6:0] ddx, ddy;
  logic        [6:0] ax, ay;
  logic        [5:0] steps_c;

  always_comb begin
    eq_x = (start_x == end_x);
    eq_y = (start_y == end_y);
    hi_x = (start_x > end_x) ? start_x : end_x;
    lo_x = (start_x > end_x) ? end_x : start_x;
    hi_y = (start_y > end_y) ? start_y : end_y;
    lo_y = (start_y > end_y) ? end_y : start_y;
    if (eq_x) begin
      // vertical or single point: walk y from the top down
      bx  = start_x;
      by  = hi_y;
      ddx = 7'sd0;
      ddy = $signed({lo_y[5], lo_y}) - $signed({hi_y[5], hi_y});
    end else if (eq_y) begin
      bx  = hi_x;
      by  = start_y;
      ddx = $signed({lo_x[5], lo_x}) - $signed({hi_x[5], hi_x});
      ddy = 7'sd0;
    end else begin
      bx  = start_x;
      by  = start_y;
      ddx = $signed({end_x[5], end_x}) - $signed({start_x[5], start_x});
      ddy = $signed({end_y[5], end_y}) - $signed({start_y[5], start_y});
    end
    ax      = ddx[6] ? 7'(-ddx) : 7'(ddx);
    ay      = ddy[6] ? 7'(-ddy) : 7'(ddy);
    steps_c = (ax > ay) ? ax[5:0] : ay[5:0];
  end

  // walk state
  logic signed [6:0] d_x_r, d_y_r;
  logic        [5:0] steps_r;
  logic signed [6:0] fq_x_r, fq_y_r, tr_x_r, tr_y_r;
  logic        [5:0] fr_x_r, fr_y_r;
  logic        [6:0] wx_r, pts_r;
  logic        [4:0] wy_r;
  logic       [23:0] colour_r;
  logic signed [7:0] vx_r, vy_r;

  axis_t             nx, ny;
  logic              done_x, done_y;
  logic        [6:0] res_x, res_y;
  logic        [6:0] sw_eff;
  logic        [4:0] sh_eff;
  logic        [6:0] wx_nxt;
  logic        [4:0] wy_nxt;

  assign sw_eff = (screen_width_r == 7'd0) ? 7'd1 : screen_width_r;
  assign sh_eff = (screen_height_r == 5'd0) ? 5'd1 : screen_height_r;

  lplr_wrap u_wrap_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.wrap_start),
    .value  (vx_r),
    .size   (screen_width_r),
    .done   (done_x),
    .result (res_x)
  );

  lplr_wrap u_wrap_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.wrap_start),
    .value  (vy_r),
    .size   ({2'b00, screen_height_r}),
    .done   (done_y),
    .result (res_y)
  );

  // the truncated coordinate moves by at most one per step
  always_comb begin
    nx = axis_step(fq_x_r, fr_x_r, d_x_r, steps_r);
    ny = axis_step(fq_y_r, fr_y_r, d_y_r, steps_r);
    wx_nxt = wx_r;
    if (nx.tr > tr_x_r) begin
      wx_nxt = (wx_r == sw_eff - 7'd1) ? 7'd0 : wx_r + 7'd1;
    end else if (nx.tr < tr_x_r) begin
      wx_nxt = (wx_r == 7'd0) ? sw_eff - 7'd1 : wx_r - 7'd1;
    end
    wy_nxt = wy_r;
    if (ny.tr > tr_y_r) begin
      wy_nxt = (wy_r == sh_eff - 5'd1) ? 5'd0 : wy_r + 5'd1;
    end else if (ny.tr < tr_y_r) begin
      wy_nxt = (wy_r == 5'd0) ? sh_eff - 5'd1 : wy_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_x_r   <= 7'sd0;
      d_y_r   <= 7'sd0;
      steps_r <= 6'd0;
      fq_x_r  <= 7'sd0;
      fq_y_r  <= 7'sd0;
      fr_x_r  <= 6'd0;
      fr_y_r  <= 6'd0;
      tr_x_r  <= 7'sd0;
      tr_y_r  <= 7'sd0;
      pts_r   <= 7'd0;
    end else if (cmd.load) begin
      d_x_r   <= ddx;
      d_y_r   <= ddy;
      steps_r <= steps_c;
      fq_x_r  <= $signed({bx[5], bx});
      fq_y_r  <= $signed({by[5], by});
      fr_x_r  <= 6'd0;
      fr_y_r  <= 6'd0;
      tr_x_r  <= $signed({bx[5], bx});
      tr_y_r  <= $signed({by[5], by});
      pts_r   <= {1'b0, steps_c} + 7'd1;
    end else if (cmd.emit) begin
      pts_r <= pts_r - 7'd1;
      if (!st.last_point) begin
        fq_x_r <= nx.fq;
        fr_x_r <= nx.fr;
        tr_x_r <= nx.tr;
        fq_y_r <= ny.fq;
        fr_y_r <= ny.fr;
        tr_y_r <= ny.tr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      colour_r <= {red_in, green_in, blue_in};
      vx_r     <= $signed({{2{bx[5]}}, bx}) + $signed({offset_x_r[6], offset_x_r});
      vy_r     <= $signed({{2{by[5]}}, by}) + $signed({offset_y_r[6], offset_y_r});
    end
    if (cmd.wrap_take) begin
      wx_r <= res_x;
      wy_r <= res_y[4:0];
    end else if (cmd.emit && !st.last_point) begin
      wx_r <= wx_nxt;
      wy_r <= wy_nxt;
    end
  end

  // panel mapping of the current wrapped point
  logic signed [15:0] mx, my, idx;

  always_comb begin
    mx = $signed({9'd0, wx_r});
    my = $signed({11'd0, wy_r});
    if (stacked_r && my >= PH_S) begin
      my = my - PH_S;
      mx = mx + PW_S;
    end
    if (zigzag_r && mx[0]) my = ZZ_S - my;
    idx = mx * PH_S + my;
  end

  // output register
  logic       out_valid_r;
  logic [8:0] out_idx_r;
  logic [23:0] out_col_r;
  logic       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r  <= idx[8:0];
      out_col_r  <= colour_r;
      out_last_r <= st.last_point;
    end
  end

  assign st.wrap_done  = done_x;
  assign st.out_free   = !out_valid_r || out_ready;
  assign st.last_point = (pts_r == 7'd1);

  assign out_valid   = out_valid_r;
  assign pixel_index = out_idx_r;
  assign red_out     = out_col_r[23:16];
  assign green_out   = out_col_r[15:8];
  assign blue_out    = out_col_r[7:0];
  assign last_pixel  = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    done_x == done_y)
    else $error("modulo units out of step");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> pts_r != 7'd0)
    else $error("pixel emitted with no points left");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !st.last_point) |=> pts_r == $past(pts_r) - 7'd1)
    else $error("point count not stepped");

  assert property (@(posedge clk) disable iff (!rst_n)
    (steps_r != 6'd0) |-> (fr_x_r < steps_r && fr_y_r < steps_r))
    else $error("dda remainder out of range");

endmodule

/* sv/led_panel_line_rasterizer_unit.sv */
// ---------------------------------------------------------------------------
// led_panel_line_rasterizer_unit: line command to LED frame-buffer writes
// Top level joining the sequencer and the rasterizer datapath.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  takes one line command (two signed endpoints and a colour) per
//          transaction; it is ready only while no line is in progress.
//   out_ch gives one pixel write per point of the line, last_pixel marks
//          the final write of the line.
//   cfg_ch writes offsets, screen size, panel stacking and zigzag layout;
//          always ready, to be written only while the unit is idle.
// Timing: after a command is taken, setup passes through load and a
//   bit-serial modulo of the first point per axis, then one pixel write
//   leaves per cycle while out_ch.ready lets the output register drain.
//   The DDA walk and incremental wrap run one point per cycle, pausing
//   whenever a write is held in the output register.
// Reset (rst_n low, synchronous) returns the sequencer to idle, drops
//   out_ch.valid and loads the register defaults.
// Stalls: a write held in the output register waits for out_ch.ready and
//   the walk pauses; once the last write is registered, a new command is
//   taken while it still waits.
// ---------------------------------------------------------------------------
module led_panel_line_rasterizer_unit import lplr_pkg::*; #(
  parameter int PANEL_WIDTH  = 32,
  parameter int PANEL_HEIGHT = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  lplr_line_if.sink    in_ch,
  lplr_pix_if.source   out_ch,
  lplr_cfg_if.sink     cfg_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  assign cfg_ch.ready = 1'b1;

  lplr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .st       (st)
  );

  lplr_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .start_x     (in_ch.start_x),
    .start_y     (in_ch.start_y),
    .end_x       (in_ch.end_x),
    .end_y       (in_ch.end_y),
    .red_in      (in_ch.red_in),
    .green_in    (in_ch.green_in),
    .blue_in     (in_ch.blue_in),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .pixel_index (out_ch.pixel_index),
    .red_out     (out_ch.red_out),
    .green_out   (out_ch.green_out),
    .blue_out    (out_ch.blue_out),
    .last_pixel  (out_ch.last_pixel)
  );

endmodule
